// ===== sv/assert_macros.svh =====
// Assertion macros shared by the transliterator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an expression at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("%m: invariant violated");
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== sv/utgt_pkg.sv =====
// Shared types, constants and Greek name tables for the transliterator.
`timescale 1ns / 1ps
package utgt_pkg;

	localparam int GREEK_COUNT    = 22;
	localparam int GREEK_IDX_W    = $clog2(GREEK_COUNT);
	localparam int NAME_MAX_LEN   = 9;
	localparam int CHAR_IDX_W     = $clog2(NAME_MAX_LEN + 1);
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FAMILY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCALE_IS_UTF8 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_SUBSCRIPTS = 2'd2;

	// Target family codes
	localparam logic [1:0] FAM_8992 = 2'd0;
	localparam logic [1:0] FAM_7386 = 2'd1;

	localparam logic [15:0] SUB_FIRST  = 16'h2080;
	localparam logic [15:0] SUB_LAST   = 16'h2089;
	localparam logic [15:0] UNIT_SLASH = 16'h002f;
	localparam logic [15:0] UNIT_UNDER = 16'h005f;

	typedef logic [GREEK_IDX_W-1:0] greek_idx_t;
	typedef logic [CHAR_IDX_W-1:0]  char_idx_t;

	typedef enum logic {
		CMD_UNIT,
		CMD_GREEK
	} cmd_kind_t;

	// One queued command: a single unit, or a Greek name to expand
	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] unit;
		greek_idx_t  gidx;
	} cmd_t;

	localparam logic [15:0] GREEK_UNIT [GREEK_COUNT] = '{
		16'h03bc, 16'h03b1, 16'h03b2, 16'h0393, 16'h03b3, 16'h0394,
		16'h03b4, 16'h03b5, 16'h03b6, 16'h03b8, 16'h03bb, 16'h03be,
		16'h03a0, 16'h03c0, 16'h03c1, 16'h03a3, 16'h03c3, 16'h03c4,
		16'h03d5, 16'h03a8, 16'h03a9, 16'h03c9
	};

	localparam logic [CHAR_IDX_W-1:0] GREEK_LEN [GREEK_COUNT] = '{
		4'd4, 4'd7, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd9, 4'd6, 4'd7, 4'd8,
		4'd5, 4'd4, 4'd4, 4'd5, 4'd7, 4'd7, 4'd5, 4'd5, 4'd5, 4'd7, 4'd7
	};

	// Names are right-justified: the last character sits in the low byte
	localparam logic [8*NAME_MAX_LEN-1:0] GREEK_TEXT [GREEK_COUNT] = '{
		"_mu_", "_alpha_", "_beta_", "_GAMMA_", "_gamma_", "_DELTA_",
		"_delta_", "_epsilon_", "_zeta_", "_theta_", "_lambda_", "_ksi_",
		"_PI_", "_pi_", "_rho_", "_SIGMA_", "_sigma_", "_tau_",
		"_PHI_", "_PSI_", "_OMEGA_", "_omega_"
	};

	// Character k (from the start) of Greek name idx
	function automatic logic [7:0] greek_char(greek_idx_t idx, char_idx_t k);
		char_idx_t                   pos;
		logic [8*NAME_MAX_LEN-1:0]   txt;
		pos = GREEK_LEN[idx] - char_idx_t'(1) - k;
		txt = GREEK_TEXT[idx] >> {pos, 3'b000};
		return txt[7:0];
	endfunction

endpackage

// ===== sv/utgt_front.sv =====
// Front end: holds configuration, accepts code units and classifies them.
`timescale 1ns / 1ps
module utgt_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [utgt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [utgt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              q_ready,
	input  logic [15:0]                       code_unit,
	output logic                              push,
	output utgt_pkg::cmd_t                    cmd
);
	import utgt_pkg::*;

	logic [1:0]  target_family_q;
	logic        locale_is_utf8_q;
	logic        map_subscripts_q;
	logic        translit;
	logic        is_sub;
	logic [15:0] sub_digit;
	logic        greek_hit;
	greek_idx_t  greek_idx;
	logic        keep;
	cmd_kind_t   kind;
	logic [15:0] unit_raw;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_family_q  <= FAM_8992;
			locale_is_utf8_q <= 1'b0;
			map_subscripts_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_FAMILY:  target_family_q  <= cfg_data;
				CFG_LOCALE_IS_UTF8: locale_is_utf8_q <= cfg_data[0];
				CFG_MAP_SUBSCRIPTS: map_subscripts_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Look up the Greek letter table
	always_comb begin
		greek_hit = 1'b0;
		greek_idx = '0;
		for (int i = 0; i < GREEK_COUNT; i++) begin
			if (code_unit == GREEK_UNIT[i]) begin
				greek_hit = 1'b1;
				greek_idx = greek_idx_t'(i);
			end
		end
	end

	assign translit  = (target_family_q == FAM_8992 || target_family_q == FAM_7386) &&
	                   !locale_is_utf8_q;
	assign is_sub    = (code_unit >= SUB_FIRST) && (code_unit <= SUB_LAST);
	assign sub_digit = {12'h003, code_unit[3:0]};

	// Classify the unit: pass, substitute, expand or drop
	always_comb begin
		keep     = 1'b1;
		kind     = CMD_UNIT;
		unit_raw = code_unit;
		priority if (code_unit == 16'h0000) begin
			keep = 1'b0;
		end else if (!translit) begin
			if (map_subscripts_q && is_sub) unit_raw = sub_digit;
		end else if (code_unit[15:8] == 8'h00) begin
			unit_raw = code_unit;
		end else if (target_family_q == FAM_7386 && is_sub) begin
			unit_raw = sub_digit;
		end else if (greek_hit) begin
			kind = CMD_GREEK;
		end else begin
			keep = 1'b0;
		end
	end

	// Replace slash on single-unit output
	assign cmd.kind = kind;
	assign cmd.unit = (unit_raw == UNIT_SLASH) ? UNIT_UNDER : unit_raw;
	assign cmd.gidx = greek_idx;
	assign push     = in_valid && q_ready && keep;

endmodule

// ===== sv/utgt_fifo.sv =====
// Command queue between front end and expansion back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utgt_fifo #(
	parameter int DEPTH = utgt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  utgt_pkg::cmd_t  wr_cmd,
	output logic            not_full,
	input  logic            pop,
	output logic            not_empty,
	output utgt_pkg::cmd_t  head
);
	import utgt_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign not_full  = (count_q != CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

	`ASSERT_ALWAYS(a_count_range, count_q <= CntW'(DEPTH))
	`ASSERT_IMPLY(a_empty_ptrs, count_q == '0, rd_ptr_q == wr_ptr_q)

endmodule

// ===== sv/utgt_back.sv =====
// Back end: expands queued commands into output units, one per cycle while not stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utgt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  utgt_pkg::cmd_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [15:0]     out_unit,
	output logic            last_of_run
);
	import utgt_pkg::*;

	char_idx_t   k_q;
	logic        out_valid_q;
	logic [15:0] out_unit_q;
	logic        last_q;
	logic        advance;
	logic        emit;
	logic [15:0] nxt_unit;
	logic        nxt_last;

	assign advance = !out_valid_q || out_ready;
	assign emit    = advance && q_not_empty;

	// Select the next unit of the head command
	always_comb begin
		unique case (head.kind)
			CMD_UNIT: begin
				nxt_unit = head.unit;
				nxt_last = 1'b1;
			end
			CMD_GREEK: begin
				nxt_unit = {8'h00, greek_char(head.gidx, k_q)};
				nxt_last = (k_q == GREEK_LEN[head.gidx] - char_idx_t'(1));
			end
			default: begin
				nxt_unit = head.unit;
				nxt_last = 1'b1;
			end
		endcase
	end

	assign pop = emit && nxt_last;

	// Step through the characters of a name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) k_q <= nxt_last ? '0 : k_q + char_idx_t'(1);
			if (advance) out_valid_q <= q_not_empty;
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_unit_q <= nxt_unit;
			last_q     <= nxt_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_unit    = out_unit_q;
	assign last_of_run = last_q;

	`ASSERT_IMPLY(a_midname_head, k_q != '0, q_not_empty && head.kind == CMD_GREEK)
	`ASSERT_IMPLY(a_partial_run, out_valid_q && !last_q, k_q != '0)

endmodule

// ===== sv/utf16_greek_name_transliterator.sv =====
// Top level of the UTF-16 Greek name transliterator.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready carries one UTF-16 code unit per
//   transaction. Output channel out_valid/out_ready carries one converted
//   unit per transaction; last_of_run marks the final unit caused by an
//   input unit. Inputs that produce nothing (zero, dropped units) emit no
//   transaction at all.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   The front end classifies a unit in the cycle it is accepted and writes
//   it to a command queue of QUEUE_DEPTH entries. The back end emits one
//   unit per cycle from the queue head unless the receiver stalls; a
//   result passes through the queue and then the output register. A
//   single-unit input yields one unit; a Greek letter yields one unit
//   per name character (4 to 9), bounded by the one-character-per-cycle
//   output register. Inputs are taken every cycle while the queue has room.
// Reset clears the configuration to zero and empties queue and output.
// When the receiver stalls, the output register holds and the queue fills;
// in_ready drops only when the queue is full.
module utf16_greek_name_transliterator #(
	parameter int QUEUE_DEPTH = utgt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [utgt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [utgt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [15:0]                     code_unit,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     out_unit,
	output logic                            last_of_run
);
	import utgt_pkg::*;

	logic push;
	logic pop;
	logic q_not_full;
	logic q_not_empty;
	cmd_t wr_cmd;
	cmd_t head;

	assign in_ready = q_not_full;

	utgt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.q_ready   (q_not_full),
		.code_unit (code_unit),
		.push      (push),
		.cmd       (wr_cmd)
	);

	utgt_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	utgt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_unit    (out_unit),
		.last_of_run (last_of_run)
	);

endmodule
